// ===== hw/rtl/gsfp_pkg.sv =====
`timescale 1ns / 1ps
package gsfp_pkg;

  localparam logic [7:0] StartByte   = 8'hFF;
  localparam logic [7:0] TypeReading = 8'h86;
  localparam logic [7:0] TypeIdent   = 8'hD7;
  localparam int unsigned FrameLen   = 9;
  localparam logic [3:0] LastPos     = 4'(FrameLen - 1);

  typedef enum logic [1:0] {
    KIND_READING  = 2'd0,
    KIND_IDENT    = 2'd1,
    KIND_CHECKSUM = 2'd2,
    KIND_RESYNC   = 2'd3
  } frame_kind_t;

  typedef struct packed {
    logic        fire;
    frame_kind_t kind;
    logic [15:0] concentration_x10;
    logic [15:0] mass_concentration;
    logic [15:0] reading_full_range;
    logic [7:0]  module_type;
    logic [15:0] module_range;
    logic [7:0]  module_unit;
    logic [3:0]  module_decimals;
    logic [31:0] resync_total;
    logic [31:0] checksum_error_total;
    logic [31:0] good_reading_total;
  } gsfp_result_t;

endpackage

// ===== hw/rtl/gsfp_frame_core.sv =====
`timescale 1ns / 1ps
module gsfp_frame_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output gsfp_pkg::gsfp_result_t res_o
);
  import gsfp_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  frame_r [1:7];
  logic [7:0]  frame_nxt [1:7];
  logic [31:0] resync_r, resync_nxt;
  logic [31:0] cksum_err_r, cksum_err_nxt;
  logic [31:0] reading_cnt_r, reading_cnt_nxt;
  logic [15:0] conc_r, conc_nxt;
  logic [15:0] mass_r, mass_nxt;
  logic [15:0] full_range_r, full_range_nxt;
  logic [7:0]  mod_type_r, mod_type_nxt;
  logic [15:0] mod_range_r, mod_range_nxt;
  logic [7:0]  mod_unit_r, mod_unit_nxt;
  logic [3:0]  mod_dec_r, mod_dec_nxt;

  logic        take;
  logic        complete;
  logic [7:0]  frame_type;
  logic [7:0]  expect_sum;
  frame_kind_t kind;

  assign take       = step_i && !(pos_r == 4'd0 && byte_i != StartByte);
  assign complete   = take && pos_r == LastPos;
  assign frame_type = frame_r[1];
  assign expect_sum = 8'(8'd0 - sum_r);

  always_comb begin
    pos_nxt         = pos_r;
    sum_nxt         = sum_r;
    frame_nxt       = frame_r;
    resync_nxt      = resync_r;
    cksum_err_nxt   = cksum_err_r;
    reading_cnt_nxt = reading_cnt_r;
    conc_nxt        = conc_r;
    mass_nxt        = mass_r;
    full_range_nxt  = full_range_r;
    mod_type_nxt    = mod_type_r;
    mod_range_nxt   = mod_range_r;
    mod_unit_nxt    = mod_unit_r;
    mod_dec_nxt     = mod_dec_r;
    kind            = KIND_RESYNC;

    if (take && !complete) begin
      for (int i = 1; i <= 7; i++) begin
        if (pos_r == 4'(i)) begin
          frame_nxt[i] = byte_i;
        end
      end
      if (pos_r != 4'd0) begin
        sum_nxt = 8'(sum_r + byte_i);
      end
      pos_nxt = 4'(pos_r + 4'd1);
    end

    if (complete) begin
      pos_nxt = 4'd0;
      sum_nxt = 8'd0;
      if (frame_type != TypeReading && frame_type != TypeIdent) begin
        kind       = KIND_RESYNC;
        resync_nxt = 32'(resync_r + 32'd1);
        // A type byte of 0xFF may itself be the start of the next frame.
        if (frame_type == StartByte) begin
          pos_nxt = 4'd1;
        end
      end else if (byte_i != expect_sum) begin
        kind          = KIND_CHECKSUM;
        cksum_err_nxt = 32'(cksum_err_r + 32'd1);
      end else if (frame_type == TypeIdent) begin
        kind          = KIND_IDENT;
        mod_type_nxt  = frame_r[2];
        mod_range_nxt = {frame_r[3], frame_r[4]};
        mod_unit_nxt  = frame_r[5];
        mod_dec_nxt   = frame_r[6][7:4];
      end else begin
        kind            = KIND_READING;
        conc_nxt        = {frame_r[6], frame_r[7]};
        mass_nxt        = {frame_r[2], frame_r[3]};
        full_range_nxt  = {frame_r[4], frame_r[5]};
        reading_cnt_nxt = 32'(reading_cnt_r + 32'd1);
      end
    end
  end

  always_comb begin
    res_o.fire                 = complete;
    res_o.kind                 = kind;
    res_o.concentration_x10    = conc_nxt;
    res_o.mass_concentration   = mass_nxt;
    res_o.reading_full_range   = full_range_nxt;
    res_o.module_type          = mod_type_nxt;
    res_o.module_range         = mod_range_nxt;
    res_o.module_unit          = mod_unit_nxt;
    res_o.module_decimals      = mod_dec_nxt;
    res_o.resync_total         = resync_nxt;
    res_o.checksum_error_total = cksum_err_nxt;
    res_o.good_reading_total   = reading_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= 4'd0;
      sum_r         <= 8'd0;
      resync_r      <= 32'd0;
      cksum_err_r   <= 32'd0;
      reading_cnt_r <= 32'd0;
      conc_r        <= 16'd0;
      mass_r        <= 16'd0;
      full_range_r  <= 16'd0;
      mod_type_r    <= 8'd0;
      mod_range_r   <= 16'd0;
      mod_unit_r    <= 8'd0;
      mod_dec_r     <= 4'd0;
    end else begin
      pos_r         <= pos_nxt;
      sum_r         <= sum_nxt;
      resync_r      <= resync_nxt;
      cksum_err_r   <= cksum_err_nxt;
      reading_cnt_r <= reading_cnt_nxt;
      conc_r        <= conc_nxt;
      mass_r        <= mass_nxt;
      full_range_r  <= full_range_nxt;
      mod_type_r    <= mod_type_nxt;
      mod_range_r   <= mod_range_nxt;
      mod_unit_r    <= mod_unit_nxt;
      mod_dec_r     <= mod_dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LastPos)
    else $error("frame position beyond the last byte");

  a_sum_clear_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == 4'd0 || pos_r == 4'd1) |-> sum_r == 8'd0)
    else $error("running checksum not clear at frame start");

  a_complete_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    complete |=> (pos_r == 4'd0 || pos_r == 4'd1))
    else $error("position not restarted after a completed frame");

  a_reading_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (complete && kind == KIND_READING) |=>
      reading_cnt_r == 32'($past(reading_cnt_r) + 32'd1))
    else $error("good reading not counted");
`endif

endmodule

// ===== hw/rtl/gas_sensor_frame_parser.sv =====
`timescale 1ns / 1ps
// Parses the nine-byte frames of a serial gas sensor, one received byte per request on the
// input stream. Bytes are dropped until a 0xFF start byte, then nine bytes make a frame; a
// result request is issued for every completed frame and for nothing else. out_tuser carries
// the frame kind (0 reading, 1 identification, 2 checksum error, 3 unknown type), and out_tdata
// always carries the last good reading and identification fields with the three wrapping
// counters as they stand after that frame. A byte is taken every cycle as long as results are
// drained; a byte passes through an input register and the frame decode into the result
// register, from which the result of each completed frame is presented. Throughput is limited
// only by the single-entry result register: while a result waits unread, at most one further
// byte is held.
module gas_sensor_frame_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] rx_byte
  output logic          out_tvalid,
  input  logic          out_tready,
  // [15:0] concentration_x10, [31:16] mass_concentration, [47:32] reading_full_range,
  // [55:48] module_type, [71:56] module_range, [79:72] module_unit,
  // [83:80] module_decimals, [115:84] resync_total, [147:116] checksum_error_total,
  // [179:148] good_reading_total, [183:180] zero
  output logic [183:0]  out_tdata,
  output logic [1:0]    out_tuser   // [1:0] frame_kind
);
  import gsfp_pkg::*;

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         out_valid_r;
  gsfp_result_t out_res_r;
  gsfp_result_t res;
  logic         advance;
  logic         step;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign step      = s1_valid_r && advance;

  gsfp_frame_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (s1_byte_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= step && res.fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
    if (step && res.fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {4'd0,
                       out_res_r.good_reading_total,
                       out_res_r.checksum_error_total,
                       out_res_r.resync_total,
                       out_res_r.module_decimals,
                       out_res_r.module_unit,
                       out_res_r.module_range,
                       out_res_r.module_type,
                       out_res_r.reading_full_range,
                       out_res_r.mass_concentration,
                       out_res_r.concentration_x10};

endmodule

// ===== tb/sv/tb_gas_sensor_frame_parser.sv =====
`timescale 1ns / 1ps
module tb_gas_sensor_frame_parser;
  import gsfp_pkg::*;

  typedef struct packed {
    frame_kind_t kind;
    logic [15:0] conc_x10;
    logic [15:0] mass;
    logic [15:0] full_range;
    logic [7:0]  mod_type;
    logic [15:0] mod_range;
    logic [7:0]  mod_unit;
    logic [3:0]  mod_dec;
    logic [31:0] resyncs;
    logic [31:0] cs_errors;
    logic [31:0] readings;
  } frame_result_t;

  typedef struct {
    logic [7:0]    rx;
    bit            typed;
    frame_result_t want;
  } dir_row_t;

  localparam int DirLen       = 27;
  localparam int RandomItems  = 550;
  localparam int HoldResult   = 40;
  localparam int HoldCycles   = 300;
  localparam int PauseFrame   = 20;
  localparam int TailCycles   = 20;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic [1:0]   out_tuser;

  always #5 clk = ~clk;

  gas_sensor_frame_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow copy of the parser state.
  logic [3:0]  parse_pos = '0;
  logic [7:0]  frame_bytes [FrameLen];
  logic [7:0]  sum_acc = '0;
  logic [31:0] resync_cnt = '0;
  logic [31:0] cserr_cnt = '0;
  logic [31:0] good_cnt = '0;
  logic [15:0] held_conc = '0;
  logic [15:0] held_mass = '0;
  logic [15:0] held_full = '0;
  logic [7:0]  held_type = '0;
  logic [15:0] held_range = '0;
  logic [7:0]  held_unit = '0;
  logic [3:0]  held_dec = '0;

  frame_result_t expected_frames [$];
  dir_row_t      dir_rows [DirLen];
  logic [7:0]    dir_bytes [DirLen];
  int unsigned   mismatches = 0;
  int unsigned   useful_bytes = 0;
  int unsigned   tx_items = 0;
  int unsigned   results_seen = 0;
  bit            tx_quiet = 1'b0;

  function automatic int unsigned draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Advances the shadow parser by one byte and reports the frame it completes, if any.
  task automatic parse_byte(input logic [7:0] rx, output bit fired, output frame_result_t res);
    logic [7:0]  want_cs;
    frame_kind_t kind;
    fired = 1'b0;
    res = '0;
    if (parse_pos == '0 && rx != StartByte) return;
    frame_bytes[parse_pos] = rx;
    if (parse_pos >= 4'd1 && parse_pos <= 4'd7) sum_acc = sum_acc + rx;
    if (parse_pos != LastPos) begin
      parse_pos = parse_pos + 4'd1;
      return;
    end
    parse_pos = '0;
    want_cs = 8'(0) - sum_acc;
    sum_acc = '0;
    if (frame_bytes[1] != TypeReading && frame_bytes[1] != TypeIdent) begin
      resync_cnt = resync_cnt + 32'd1;
      // A start byte in the type position opens a fresh frame at once.
      if (frame_bytes[1] == StartByte) begin
        frame_bytes[0] = StartByte;
        parse_pos = 4'd1;
      end
      kind = KIND_RESYNC;
    end else if (frame_bytes[8] != want_cs) begin
      cserr_cnt = cserr_cnt + 32'd1;
      kind = KIND_CHECKSUM;
    end else if (frame_bytes[1] == TypeIdent) begin
      held_type  = frame_bytes[2];
      held_range = {frame_bytes[3], frame_bytes[4]};
      held_unit  = frame_bytes[5];
      held_dec   = frame_bytes[6][7:4];
      kind = KIND_IDENT;
    end else begin
      held_mass = {frame_bytes[2], frame_bytes[3]};
      held_full = {frame_bytes[4], frame_bytes[5]};
      held_conc = {frame_bytes[6], frame_bytes[7]};
      good_cnt = good_cnt + 32'd1;
      kind = KIND_READING;
    end
    fired          = 1'b1;
    res.kind       = kind;
    res.conc_x10   = held_conc;
    res.mass       = held_mass;
    res.full_range = held_full;
    res.mod_type   = held_type;
    res.mod_range  = held_range;
    res.mod_unit   = held_unit;
    res.mod_dec    = held_dec;
    res.resyncs    = resync_cnt;
    res.cs_errors  = cserr_cnt;
    res.readings   = good_cnt;
  endtask

  // Offers one byte after a random gap and records what its acceptance should produce.
  task automatic send_byte(input logic [7:0] rx, input bit typed, input frame_result_t want);
    int unsigned   gap;
    bit            fired;
    frame_result_t predicted;
    if (tx_items % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    tx_items++;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (parse_pos != '0 || rx == StartByte) useful_bytes++;
    parse_byte(rx, fired, predicted);
    if (fired) expected_frames.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("field %s differs: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = frame_kind_t'(out_tuser);
      got.conc_x10   = out_tdata[15:0];
      got.mass       = out_tdata[31:16];
      got.full_range = out_tdata[47:32];
      got.mod_type   = out_tdata[55:48];
      got.mod_range  = out_tdata[71:56];
      got.mod_unit   = out_tdata[79:72];
      got.mod_dec    = out_tdata[83:80];
      got.resyncs    = out_tdata[115:84];
      got.cs_errors  = out_tdata[147:116];
      got.readings   = out_tdata[179:148];
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result request with nothing outstanding: kind %0d",
                                       out_tuser);
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_kind", 32'(want.kind), 32'(got.kind));
        check_field("concentration_x10", 32'(want.conc_x10), 32'(got.conc_x10));
        check_field("mass_concentration", 32'(want.mass), 32'(got.mass));
        check_field("reading_full_range", 32'(want.full_range), 32'(got.full_range));
        check_field("module_type", 32'(want.mod_type), 32'(got.mod_type));
        check_field("module_range", 32'(want.mod_range), 32'(got.mod_range));
        check_field("module_unit", 32'(want.mod_unit), 32'(got.mod_unit));
        check_field("module_decimals", 32'(want.mod_dec), 32'(got.mod_dec));
        check_field("resync_total", want.resyncs, got.resyncs);
        check_field("checksum_error_total", want.cs_errors, got.cs_errors);
        check_field("good_reading_total", want.readings, got.readings);
      end
    end
  end

  // Result side: a random stall before each request, with one long hold-off to back up the input.
  initial begin : rx_side
    int unsigned wait_cycles;
    bit          rx_quiet;
    rx_quiet = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen % 16 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      wait_cycles = (results_seen == HoldResult) ? HoldCycles : draw_gap(rx_quiet);
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
    end
  end

  initial begin : tx_side
    frame_result_t none;
    logic [7:0]    fb [$];
    logic [7:0]    cs;
    logic [7:0]    kind_byte;
    int unsigned   pick;
    int unsigned   frames;
    none = '0;
    // Noise while hunting, an unknown type, a start byte in the type position that
    // restarts collection, then a reading of extreme bytes completed from that restart.
    dir_bytes = '{8'h00,
                  8'hFF, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                  8'h86, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7D};
    for (int i = 0; i < DirLen; i++) begin
      dir_rows[i].rx    = dir_bytes[i];
      dir_rows[i].typed = 1'b0;
      dir_rows[i].want  = '0;
    end
    dir_rows[9].typed          = 1'b1;
    dir_rows[9].want.kind      = KIND_RESYNC;
    dir_rows[9].want.resyncs   = 32'd1;
    dir_rows[18].typed         = 1'b1;
    dir_rows[18].want.kind     = KIND_RESYNC;
    dir_rows[18].want.resyncs  = 32'd2;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirLen; i++) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

    frames = 0;
    while (useful_bytes < RandomItems) begin
      fb.delete();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Line noise without a start byte; mid-frame it breaks the frame alignment.
        repeat ($urandom_range(1, 5)) fb.push_back(8'($urandom_range(0, 254)));
      end else begin
        if (parse_pos != 4'd1) fb.push_back(StartByte);
        if (pick < 50) begin
          kind_byte = TypeReading;
        end else if (pick < 75) begin
          kind_byte = TypeIdent;
        end else if (pick < 85) begin
          kind_byte = $urandom_range(0, 1) ? TypeReading : TypeIdent;
        end else if ($urandom_range(0, 2) == 0) begin
          kind_byte = StartByte;
        end else begin
          kind_byte = 8'($urandom_range(0, 255));
          while (kind_byte == TypeReading || kind_byte == TypeIdent)
            kind_byte = 8'($urandom_range(0, 255));
        end
        fb.push_back(kind_byte);
        repeat (6) fb.push_back(payload_byte());
        cs = '0;
        for (int k = fb.size() - 7; k < fb.size(); k++) cs = cs + fb[k];
        cs = 8'(0) - cs;
        if (pick >= 75 && pick < 85) cs = cs + 8'($urandom_range(1, 255));
        fb.push_back(cs);
      end
      foreach (fb[k]) send_byte(fb[k], 1'b0, none);
      frames++;
      if (frames == PauseFrame) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_frames.size() != 0) @(posedge clk);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
